// File: design/dcia_pkg.sv
package dcia_pkg;

    localparam int KEY_QUEUE_DEPTH = 8;
    localparam int KQ_IDX_W = $clog2(KEY_QUEUE_DEPTH);
    localparam int KQ_PTR_W = KQ_IDX_W + 1;

    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_TICK  = 3'd2,
        OP_COUNT = 3'd3,
        OP_KEY   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ADDR = 2'd1,
        ST_KEY_FULL = 2'd2,
        ST_SER_MODE = 2'd3
    } status_t;

    localparam logic [3:0] R_PRA   = 4'd0;
    localparam logic [3:0] R_PRB   = 4'd1;
    localparam logic [3:0] R_DDRA  = 4'd2;
    localparam logic [3:0] R_DDRB  = 4'd3;
    localparam logic [3:0] R_TALO  = 4'd4;
    localparam logic [3:0] R_TAHI  = 4'd5;
    localparam logic [3:0] R_TBLO  = 4'd6;
    localparam logic [3:0] R_TBHI  = 4'd7;
    localparam logic [3:0] R_EVLO  = 4'd8;
    localparam logic [3:0] R_EVMID = 4'd9;
    localparam logic [3:0] R_EVHI  = 4'd10;
    localparam logic [3:0] R_SDR   = 4'd12;
    localparam logic [3:0] R_ICR   = 4'd13;
    localparam logic [3:0] R_CRA   = 4'd14;
    localparam logic [3:0] R_CRB   = 4'd15;

    localparam int CR_START   = 0;
    localparam int CR_ONESHOT = 3;
    localparam int CR_LOAD    = 4;
    localparam int CR_SPOUT   = 6;
    localparam int CR_ALARM   = 7;

    // Registered input request.
    typedef struct packed {
        op_t         op;
        logic [23:0] bus_address;
        logic [7:0]  write_data;
        logic        tod_chip;
        logic        key_pressed;
        logic [6:0]  key_code;
    } req_t;

    // Result of one request.
    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] irq_lines;
        logic       overlay;
        logic       power_led;
        status_t    status;
    } res_t;

    // Address decode result.
    typedef struct packed {
        logic       ok;
        logic       chip;
        logic [3:0] regno;
    } dec_t;

    function automatic dec_t decode(input logic [23:0] a);
        dec_t d;
        d.chip  = ~a[0];
        d.regno = a[11:8];
        d.ok    = (a[7:4] == 4'd0) &&
                  ((a[0] && a >= 24'hBFE001 && a <= 24'hBFEF01) ||
                   (!a[0] && a >= 24'hBFD000 && a <= 24'hBFDF00));
        return d;
    endfunction

endpackage

// File: design/dcia_keyq.sv
module dcia_keyq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic [7:0]                    push_data,
    input  logic                          pop,
    output logic                          full,
    output logic                          empty,
    output logic [7:0]                    head_data
);

    logic [7:0]                   mem [dcia_pkg::KEY_QUEUE_DEPTH];
    logic [dcia_pkg::KQ_PTR_W-1:0] head_reg;
    logic [dcia_pkg::KQ_PTR_W-1:0] tail_reg;

    // Pointers run modulo twice the depth; the top bit tells full from empty.
    assign empty = (head_reg == tail_reg);
    assign full  = (head_reg[dcia_pkg::KQ_IDX_W] != tail_reg[dcia_pkg::KQ_IDX_W]) &&
                   (head_reg[dcia_pkg::KQ_IDX_W-1:0] == tail_reg[dcia_pkg::KQ_IDX_W-1:0]);
    assign head_data = mem[tail_reg[dcia_pkg::KQ_IDX_W-1:0]];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem[head_reg[dcia_pkg::KQ_IDX_W-1:0]] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            if (push && !full) begin
                head_reg <= head_reg + 1'b1;
            end
            if (pop && !empty) begin
                tail_reg <= tail_reg + 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_both_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(full && empty)) else $error("key queue both full and empty");
    a_push_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (full && push && !pop) |=> $stable(head_reg)) else $error("push into full queue");
    a_pop_empty_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (empty && pop) |=> $stable(tail_reg)) else $error("pop from empty queue");
`endif

endmodule

// File: design/dcia_regs.sv
module dcia_regs (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            req_valid,
    input  dcia_pkg::req_t  req,
    output dcia_pkg::res_t  res
);

    logic [7:0]  pout_reg [4];
    logic [7:0]  pdir_reg [4];
    logic [7:0]  cr_reg   [4];
    logic [15:0] rld_reg  [4];
    logic [15:0] cnt_reg  [4];
    logic [6:0]  ien_reg  [2];
    logic [7:0]  ifl_reg  [2];
    logic [7:0]  sdr_reg  [2];
    logic [23:0] ev_reg   [2];
    logic [24:0] snap_reg [2];
    logic [23:0] alm_reg  [2];
    logic        ack_reg;

    logic [7:0]  pout_next [4];
    logic [7:0]  pdir_next [4];
    logic [7:0]  cr_next   [4];
    logic [15:0] rld_next  [4];
    logic [15:0] cnt_next  [4];
    logic [6:0]  ien_next  [2];
    logic [7:0]  ifl_next  [2];
    logic [7:0]  sdr_next  [2];
    logic [23:0] ev_next   [2];
    logic [24:0] snap_next [2];
    logic [23:0] alm_next  [2];
    logic        ack_next;

    logic        kq_push, kq_pop, kq_full, kq_empty;
    logic [7:0]  kq_head;
    logic [7:0]  kq_data;

    dcia_pkg::dec_t dec;

    assign dec     = dcia_pkg::decode(req.bus_address);
    assign kq_data = {~req.key_code, req.key_pressed};

    dcia_keyq u_keyq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (kq_push),
        .push_data (kq_data),
        .pop       (kq_pop),
        .full      (kq_full),
        .empty     (kq_empty),
        .head_data (kq_head)
    );

    // Next-state and result logic for one request.
    always_comb begin
        logic [1:0]  t;
        logic [23:0] v;
        logic [7:0]  w;
        logic [7:0]  m;
        logic        c;
        logic [2:0]  sh;
        pout_next = pout_reg;
        pdir_next = pdir_reg;
        cr_next   = cr_reg;
        rld_next  = rld_reg;
        cnt_next  = cnt_reg;
        ien_next  = ien_reg;
        ifl_next  = ifl_reg;
        sdr_next  = sdr_reg;
        ev_next   = ev_reg;
        snap_next = snap_reg;
        alm_next  = alm_reg;
        ack_next  = ack_reg;
        kq_push   = 1'b0;
        kq_pop    = 1'b0;
        res.read_data = 8'd0;
        res.status    = dcia_pkg::ST_OK;
        t  = '0;
        v  = '0;
        w  = req.write_data;
        m  = '0;
        c  = dec.chip;
        sh = '0;
        if (req_valid) begin
            case (req.op)
                dcia_pkg::OP_READ: begin
                    if (!dec.ok) begin
                        res.read_data = 8'hFF;
                        res.status    = dcia_pkg::ST_BAD_ADDR;
                    end else begin
                        v = snap_reg[c][24] ? snap_reg[c][23:0] : ev_reg[c];
                        case (dec.regno)
                            dcia_pkg::R_PRA, dcia_pkg::R_PRB: begin
                                t = {c, dec.regno[0]};
                                res.read_data = (pout_reg[t] & pdir_reg[t]) | ~pdir_reg[t];
                            end
                            dcia_pkg::R_DDRA, dcia_pkg::R_DDRB:
                                res.read_data = pdir_reg[{c, dec.regno[0]}];
                            dcia_pkg::R_TALO: res.read_data = cnt_reg[{c, 1'b0}][7:0];
                            dcia_pkg::R_TAHI: res.read_data = cnt_reg[{c, 1'b0}][15:8];
                            dcia_pkg::R_TBLO: res.read_data = cnt_reg[{c, 1'b1}][7:0];
                            dcia_pkg::R_TBHI: res.read_data = cnt_reg[{c, 1'b1}][15:8];
                            dcia_pkg::R_EVLO: begin
                                res.read_data = v[7:0];
                                snap_next[c]  = '0;
                            end
                            dcia_pkg::R_EVMID: res.read_data = v[15:8];
                            dcia_pkg::R_EVHI: begin
                                snap_next[c]  = {1'b1, ev_reg[c]};
                                res.read_data = ev_reg[c][23:16];
                            end
                            dcia_pkg::R_SDR: res.read_data = sdr_reg[c];
                            dcia_pkg::R_ICR: begin
                                res.read_data = ifl_reg[c];
                                ifl_next[c]   = '0;
                            end
                            dcia_pkg::R_CRA, dcia_pkg::R_CRB:
                                res.read_data = cr_reg[{c, dec.regno[0]}];
                            default: res.read_data = 8'hFF;
                        endcase
                    end
                end
                dcia_pkg::OP_WRITE: begin
                    if (!dec.ok) begin
                        res.status = dcia_pkg::ST_BAD_ADDR;
                    end else begin
                        t = {c, dec.regno[1]};
                        case (dec.regno)
                            dcia_pkg::R_PRA, dcia_pkg::R_PRB:
                                pout_next[{c, dec.regno[0]}] = w;
                            dcia_pkg::R_DDRA, dcia_pkg::R_DDRB:
                                pdir_next[{c, dec.regno[0]}] = w;
                            dcia_pkg::R_TALO, dcia_pkg::R_TBLO:
                                rld_next[t][7:0] = w;
                            dcia_pkg::R_TAHI, dcia_pkg::R_TBHI: begin
                                rld_next[t][15:8] = w;
                                if (cr_reg[t][dcia_pkg::CR_ONESHOT]) begin
                                    cnt_next[t] = {w, rld_reg[t][7:0]};
                                    cr_next[t][dcia_pkg::CR_START] = 1'b1;
                                end
                            end
                            dcia_pkg::R_EVLO, dcia_pkg::R_EVMID, dcia_pkg::R_EVHI: begin
                                sh = {dec.regno[1:0], 3'b000} == 5'd0 ? 3'd0 :
                                     (dec.regno[1:0] == 2'd1 ? 3'd1 : 3'd2);
                                if (cr_reg[{c, 1'b1}][dcia_pkg::CR_ALARM]) begin
                                    case (sh)
                                        3'd0:    alm_next[c][7:0]   = w;
                                        3'd1:    alm_next[c][15:8]  = w;
                                        default: alm_next[c][23:16] = w;
                                    endcase
                                end else begin
                                    case (sh)
                                        3'd0:    ev_next[c][7:0]   = w;
                                        3'd1:    ev_next[c][15:8]  = w;
                                        default: ev_next[c][23:16] = w;
                                    endcase
                                end
                            end
                            dcia_pkg::R_SDR: begin
                                if (!cr_reg[{c, 1'b0}][dcia_pkg::CR_SPOUT]) begin
                                    res.status = dcia_pkg::ST_SER_MODE;
                                end else begin
                                    ack_next   = 1'b1;
                                    sdr_next[c] = w;
                                end
                            end
                            dcia_pkg::R_ICR: begin
                                if (w[7]) ien_next[c] = ien_reg[c] | w[6:0];
                                else      ien_next[c] = ien_reg[c] & ~w[6:0];
                            end
                            dcia_pkg::R_CRA, dcia_pkg::R_CRB: begin
                                t = {c, dec.regno[0]};
                                if (w[dcia_pkg::CR_LOAD]) begin
                                    w[dcia_pkg::CR_LOAD] = 1'b0;
                                    cnt_next[t] = rld_reg[t];
                                    if (w[dcia_pkg::CR_ONESHOT]) w[dcia_pkg::CR_START] = 1'b1;
                                end
                                cr_next[t] = w;
                            end
                            default: ;
                        endcase
                    end
                end
                dcia_pkg::OP_TICK: begin
                    // Four timers count in parallel; each raises its own flag.
                    for (int k = 0; k < 4; k++) begin
                        if (cr_reg[k][dcia_pkg::CR_START]) begin
                            if (cnt_reg[k] == 16'd0) begin
                                if (cr_reg[k][dcia_pkg::CR_ONESHOT]) begin
                                    cnt_next[k] = 16'hFFFF;
                                    cr_next[k][dcia_pkg::CR_START] = 1'b0;
                                end else begin
                                    cnt_next[k] = rld_reg[k];
                                end
                                ifl_next[k/2][k%2] = 1'b1;
                                if (ien_reg[k/2][k%2]) ifl_next[k/2][7] = 1'b1;
                            end else begin
                                cnt_next[k] = cnt_reg[k] - 16'd1;
                            end
                        end
                    end
                    // Hand the oldest key to the serial register of chip 0.
                    if (!kq_empty && ack_reg && !cr_reg[0][dcia_pkg::CR_SPOUT]) begin
                        ack_next    = 1'b0;
                        sdr_next[0] = kq_head;
                        kq_pop      = 1'b1;
                        ifl_next[0][3] = 1'b1;
                        if (ien_reg[0][3]) ifl_next[0][7] = 1'b1;
                    end
                end
                dcia_pkg::OP_COUNT:
                    ev_next[req.tod_chip] = ev_reg[req.tod_chip] + 24'd1;
                dcia_pkg::OP_KEY: begin
                    if (kq_full) res.status = dcia_pkg::ST_KEY_FULL;
                    else         kq_push    = 1'b1;
                end
                default: ;
            endcase
        end
        m = (pout_next[0] & pdir_next[0]) | ~pdir_next[0];
        res.irq_lines = {ifl_next[1][7], ifl_next[0][7]};
        res.overlay   = m[0];
        res.power_led = ~m[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                pout_reg[i] <= '0;
                pdir_reg[i] <= '0;
                cr_reg[i]   <= '0;
                rld_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                ien_reg[i]  <= '0;
                ifl_reg[i]  <= '0;
                sdr_reg[i]  <= '0;
                ev_reg[i]   <= '0;
                snap_reg[i] <= '0;
                alm_reg[i]  <= '0;
            end
            ack_reg <= 1'b1;
        end else begin
            pout_reg <= pout_next;
            pdir_reg <= pdir_next;
            cr_reg   <= cr_next;
            rld_reg  <= rld_next;
            cnt_reg  <= cnt_next;
            ien_reg  <= ien_next;
            ifl_reg  <= ifl_next;
            sdr_reg  <= sdr_next;
            ev_reg   <= ev_next;
            snap_reg <= snap_next;
            alm_reg  <= alm_next;
            ack_reg  <= ack_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_load_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        !cr_reg[0][dcia_pkg::CR_LOAD] && !cr_reg[2][dcia_pkg::CR_LOAD])
        else $error("force load bit stored");
    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !req_valid |=> $stable(ev_reg[0]) && $stable(ifl_reg[0]))
        else $error("state changed without a request");
    a_pop_clears_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        kq_pop |=> !ack_reg) else $error("key handed over without ack drop");
`endif

endmodule

// File: design/dual_cia_timer_interrupt_unit_core.sv
// Path: the request is registered in the input register, and its result is registered
// in the output register, or in the skid stage while the output stalls.
// Throughput: one request per cycle while m_tready is high, all work done in a single
// pass; a skid stage holds the in-flight result while the output stalls.
// Reset: aresetn synchronous, active low; valid flags and register-file state cleared, key ack set,
// the key queue pointers cleared; request and result data and key queue storage left unset.
module dual_cia_timer_interrupt_unit_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: op[2:0], bus_address[26:3], write_data[34:27], tod_chip[35],
    // key_pressed[36], key_code[43:37], zero fill [47:44]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: read_data[7:0], irq_lines[9:8], overlay[10], power_led[11],
    // status[13:12], zero fill [15:14]
    output logic [15:0] m_tdata
);

    dcia_pkg::req_t req_reg;
    logic           req_vld_reg;
    dcia_pkg::res_t res;
    dcia_pkg::res_t out_reg, skid_reg;
    logic           out_vld_reg, skid_vld_reg;
    logic           fire;

    // Accept only while a slot is certain to be free for the result of this request.
    assign s_tready = !skid_vld_reg && !(out_vld_reg && req_vld_reg && !m_tready);
    assign fire     = s_tvalid && s_tready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_vld_reg <= 1'b0;
        end else begin
            req_vld_reg <= fire;
        end
        if (fire) begin
            req_reg.op          <= dcia_pkg::op_t'(s_tdata[2:0]);
            req_reg.bus_address <= s_tdata[26:3];
            req_reg.write_data  <= s_tdata[34:27];
            req_reg.tod_chip    <= s_tdata[35];
            req_reg.key_pressed <= s_tdata[36];
            req_reg.key_code    <= s_tdata[43:37];
        end
    end

    dcia_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_vld_reg),
        .req       (req_reg),
        .res       (res)
    );

    // Output register with a skid stage behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (!out_vld_reg || m_tready) begin
                if (skid_vld_reg) begin
                    out_reg      <= skid_reg;
                    out_vld_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                    if (req_vld_reg) begin
                        skid_reg     <= res;
                        skid_vld_reg <= 1'b1;
                    end
                end else begin
                    out_reg     <= res;
                    out_vld_reg <= req_vld_reg;
                end
            end else if (req_vld_reg) begin
                skid_reg     <= res;
                skid_vld_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_reg.status, out_reg.power_led, out_reg.overlay,
                       out_reg.irq_lines, out_reg.read_data};

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg) else $error("skid full with output empty");
    a_no_accept_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> !fire) else $error("request taken with skid full");
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        req_vld_reg |=> out_vld_reg) else $error("result lost");
`endif

endmodule
